/* src/cbp_pkg.sv */
// cbp_pkg: shared types, record layout constants and the crc-32 byte update
// for the settings record parser; no dependencies
`default_nettype none

package cbp_pkg;

  // record layout, byte positions within the 50-byte record
  localparam logic [5:0] POS_VERSION  = 6'd4;
  localparam logic [5:0] POS_LENGTH   = 6'd6;
  localparam logic [5:0] POS_REVISION = 6'd8;
  localparam logic [5:0] POS_WORDS    = 6'd16;
  localparam logic [5:0] POS_BATCH    = 6'd44;
  localparam logic [5:0] POS_CRC      = 6'd46;
  localparam logic [5:0] REC_BYTES    = 6'd50;
  localparam logic [5:0] LAST_POS     = 6'd49;

  localparam int unsigned NUM_WORDS = 7;

  localparam logic [15:0] WANT_VERSION = 16'd1;
  localparam logic [15:0] WANT_PAYLOAD = 16'd38;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_ONES = 32'hffffffff;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_LENGTH  = 3'd1,
    STAT_MAGIC   = 3'd2,
    STAT_VERSION = 3'd3,
    STAT_PAYLOAD = 3'd4,
    STAT_CRC     = 3'd5
  } status_t;

  // one byte handed from the input register to the record state
  typedef struct packed {
    logic       take;
    logic       last;
    logic [7:0] data;
  } step_t;

  // record state as seen by the result logic
  typedef struct packed {
    logic [5:0]                 pos;
    logic                       magic_good;
    logic [15:0]                version;
    logic [15:0]                length;
    logic [63:0]                revision;
    logic [NUM_WORDS-1:0][31:0] words;
    logic [15:0]                batch;
    logic [31:0]                crc_tail;
  } rec_view_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h4d;  // 'M'
      2'd1:    b = 8'h35;  // '5'
      2'd2:    b = 8'h43;  // 'C'
      default: b = 8'h46;  // 'F'
    endcase
    return b;
  endfunction

  // reflected crc-32, one byte, eight shift steps unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/cbp_byte_if.sv */
// cbp_byte_if: valid/ready channel carrying record bytes with a last flag
// standalone, no package dependency
`default_nettype none

interface cbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* src/cbp_result_if.sv */
// cbp_result_if: valid/ready channel carrying one parse result per record
// standalone, no package dependency
`default_nettype none

interface cbp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] revision;
  logic [31:0] minimum_on_ms;
  logic [31:0] motion_hold_ms;
  logic [31:0] sound_hold_ms;
  logic [31:0] sound_bridge_ms;
  logic [31:0] cooldown_ms;
  logic [31:0] sound_factor_bits;
  logic [31:0] telemetry_interval_ms;
  logic [15:0] batch_size;

  modport source (
    output valid, output status, output revision, output minimum_on_ms,
    output motion_hold_ms, output sound_hold_ms, output sound_bridge_ms,
    output cooldown_ms, output sound_factor_bits, output telemetry_interval_ms,
    output batch_size, input ready
  );
  modport sink (
    input valid, input status, input revision, input minimum_on_ms,
    input motion_hold_ms, input sound_hold_ms, input sound_bridge_ms,
    input cooldown_ms, input sound_factor_bits, input telemetry_interval_ms,
    input batch_size, output ready
  );
endinterface

`default_nettype wire

/* src/cbp_crc_unit.sv */
// cbp_crc_unit: running reflected crc-32 over record bytes 0 to 45
// depends on cbp_pkg
`default_nettype none

module cbp_crc_unit
  import cbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire step_t       step,
  input  wire logic [5:0]  pos,
  output logic [31:0]      crc
);

  logic [31:0] crc_next;

  always_comb begin
    crc_next = crc;
    priority if (step.take && step.last) begin
      crc_next = CRC_ONES;
    end else if (step.take && (pos < POS_CRC)) begin
      crc_next = crc_byte(crc, step.data);
    end else begin
      crc_next = crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_ONES;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

`default_nettype wire

/* src/cbp_field_store.sv */
// cbp_field_store: byte position, magic check and little-endian field capture
// depends on cbp_pkg
`default_nettype none

module cbp_field_store
  import cbp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire step_t  step,
  output rec_view_t   view
);

  logic [5:0]                 pos;
  logic                       magic_good;
  logic [15:0]                version_word;
  logic [15:0]                length_word;
  logic [63:0]                revision_store;
  logic [NUM_WORDS-1:0][31:0] word_store;
  logic [15:0]                batch_store;
  logic [31:0]                received_crc;
  logic [5:0]                 word_off;
  logic [2:0]                 word_idx;

  assign word_off = pos - POS_WORDS;
  assign word_idx = word_off[4:2];

  // control state, back to start after every final byte
  always_ff @(posedge clk) begin
    if (rst || (step.take && step.last)) begin
      pos        <= '0;
      magic_good <= 1'b1;
    end else if (step.take && (pos < REC_BYTES)) begin
      pos <= pos + 6'd1;
      if ((pos < POS_VERSION) && (step.data != magic_byte(pos[1:0]))) begin
        magic_good <= 1'b0;
      end
    end
  end

  // payload capture, bytes shift in from the top
  always_ff @(posedge clk) begin
    if (step.take && (pos < REC_BYTES)) begin
      priority if (pos < POS_VERSION) begin
        // magic handled above
      end else if (pos < POS_LENGTH) begin
        version_word <= {step.data, version_word[15:8]};
      end else if (pos < POS_REVISION) begin
        length_word <= {step.data, length_word[15:8]};
      end else if (pos < POS_WORDS) begin
        revision_store <= {step.data, revision_store[63:8]};
      end else if (pos < POS_BATCH) begin
        word_store[word_idx] <= {step.data, word_store[word_idx][31:8]};
      end else if (pos < POS_CRC) begin
        batch_store <= {step.data, batch_store[15:8]};
      end else begin
        received_crc <= {step.data, received_crc[31:8]};
      end
    end
  end

  assign view.pos        = pos;
  assign view.magic_good = magic_good;
  assign view.version    = version_word;
  assign view.length     = length_word;
  assign view.revision   = revision_store;
  assign view.words      = word_store;
  assign view.batch      = batch_store;
  assign view.crc_tail   = received_crc;

endmodule

`default_nettype wire

/* src/config_blob_parser_crc32.sv */
// config_blob_parser_crc32: top level of the settings record parser
// depends on cbp_pkg, cbp_byte_if, cbp_result_if, cbp_crc_unit, cbp_field_store
//
// Streams a 50-byte settings record in one byte per transfer on `stream`,
// with last_byte marking the final byte, and returns one result transfer on
// `result` per record: a status and the decoded fields. The record is the
// magic "M5CF", version 1, payload length 38, a 64-bit revision, seven 32-bit
// words, a 16-bit batch size and a reflected crc-32 over bytes 0 to 45, all
// little-endian. Status reports the first failure of: wrong length, bad magic,
// bad version, bad payload length, crc mismatch; on failure all fields read
// zero. Throughput is one byte per cycle: each byte is held in the input
// register, then the crc unit and field store take it while the status logic
// loads the result register, so a result is valid in the cycle after its last
// byte is taken. The only stall comes from the result register: while it is
// full and not taken, a final byte waits in the input register, and stream
// ready falls when the input register cannot drain. After each result the
// parser restarts for the next record; bytes past the 50th are ignored.
`default_nettype none

module config_blob_parser_crc32
  import cbp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  cbp_byte_if.sink       stream,
  cbp_result_if.source   result
);

  // input register
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;

  // pipeline control
  logic       out_free;   // result register may load this cycle
  logic       in_go;      // input register byte is consumed this cycle
  logic       stream_go;  // stream transfer this cycle
  logic       res_go;     // result transfer this cycle

  step_t       step;
  rec_view_t   view;
  logic [31:0] crc;
  logic [31:0] crc_rx;
  status_t     status_next;

  assign res_go    = result.valid && result.ready;
  assign out_free  = !result.valid || result.ready;
  assign in_go     = in_valid && (!in_last || out_free);
  assign stream.ready = !in_valid || in_go;
  assign stream_go = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream_go) begin
      in_valid <= 1'b1;
    end else if (in_go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream_go) begin
      in_data <= stream.data_byte;
      in_last <= stream.last_byte;
    end
  end

  assign step.take = in_go;
  assign step.last = in_last;
  assign step.data = in_data;

  cbp_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .pos  (view.pos),
    .crc  (crc)
  );

  cbp_field_store u_store (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .view (view)
  );

  // stored crc including the byte being taken now (byte 49 on a good record)
  assign crc_rx = {in_data, view.crc_tail[31:8]};

  // first failure wins
  always_comb begin
    priority if (view.pos != LAST_POS) begin
      status_next = STAT_LENGTH;
    end else if (!view.magic_good) begin
      status_next = STAT_MAGIC;
    end else if (view.version != WANT_VERSION) begin
      status_next = STAT_VERSION;
    end else if (view.length != WANT_PAYLOAD) begin
      status_next = STAT_PAYLOAD;
    end else if (crc_rx != (crc ^ CRC_ONES)) begin
      status_next = STAT_CRC;
    end else begin
      status_next = STAT_OK;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (in_go && in_last) begin
      result.valid <= 1'b1;
    end else if (res_go) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && in_last) begin
      result.status <= status_next;
      if (status_next == STAT_OK) begin
        result.revision              <= view.revision;
        result.minimum_on_ms         <= view.words[0];
        result.motion_hold_ms        <= view.words[1];
        result.sound_hold_ms         <= view.words[2];
        result.sound_bridge_ms       <= view.words[3];
        result.cooldown_ms           <= view.words[4];
        result.sound_factor_bits     <= view.words[5];
        result.telemetry_interval_ms <= view.words[6];
        result.batch_size            <= view.batch;
      end else begin
        result.revision              <= '0;
        result.minimum_on_ms         <= '0;
        result.motion_hold_ms        <= '0;
        result.sound_hold_ms         <= '0;
        result.sound_bridge_ms       <= '0;
        result.cooldown_ms           <= '0;
        result.sound_factor_bits     <= '0;
        result.telemetry_interval_ms <= '0;
        result.batch_size            <= '0;
      end
    end
  end

  // byte position never runs past the record length
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    view.pos <= REC_BYTES)
    else $error("byte position beyond record length");

  // a final byte restarts the record state
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (in_go && in_last) |=> (view.pos == 6'd0) && view.magic_good && (crc == CRC_ONES))
    else $error("record state not restarted after final byte");

  // a final byte always produces a result
  a_result: assert property (@(posedge clk) disable iff (rst)
    (in_go && in_last) |=> result.valid)
    else $error("final byte without result");

  // failed records carry zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status != STAT_OK)) |->
      (result.revision == 64'd0) && (result.batch_size == 16'd0) &&
      (result.minimum_on_ms == 32'd0))
    else $error("failed record with nonzero fields");

endmodule

`default_nettype wire

/* tb/config_blob_parser_crc32_tb.sv */
// config_blob_parser_crc32_tb: self-checking bench for the settings record parser
// depends on cbp_pkg, cbp_byte_if, cbp_result_if and config_blob_parser_crc32
// directed record table first, then random records, each result checked per field
`timescale 1ns / 100ps

module config_blob_parser_crc32_tb;
  import cbp_pkg::*;

  // bench knobs
  localparam int unsigned IDLE_PCT       = 29;    // percent of cycles each side idles
  localparam int unsigned RANDOM_BYTES   = 460;   // byte transfers in the random part
  localparam int unsigned RANDOM_RECORDS = 8;     // and at least this many random records
  localparam int unsigned STALL_LIMIT    = 2000;  // cycles without any transfer
  localparam int unsigned DRAIN_CYCLES   = 10;    // run on after the last result is taken
  localparam int unsigned MAX_REC_BYTES  = 60;

  // 'M' '5' 'C' 'F', first byte in the low bits
  localparam logic [31:0] MAGIC_WORD = 32'h4643354d;

  // record corruptions, combined as a mask
  localparam logic [3:0] CLEAN       = 4'b0000;
  localparam logic [3:0] BAD_MAGIC   = 4'b0001;
  localparam logic [3:0] BAD_VERSION = 4'b0010;
  localparam logic [3:0] BAD_PAYLOAD = 4'b0100;
  localparam logic [3:0] BAD_CRC     = 4'b1000;

  // how the decoded fields of a record are filled
  typedef enum logic [1:0] {
    FILL_ZERO,
    FILL_ONES,
    FILL_RAND
  } fill_e;

  // one parse result as the result channel carries it
  typedef struct packed {
    status_t                    status;
    logic [63:0]                revision;
    logic [NUM_WORDS-1:0][31:0] words;
    logic [15:0]                batch;
  } parse_result_t;

  // one byte transfer, with the hand-typed result that its record must give
  typedef struct {
    logic [7:0]    data;
    logic          last;
    logic          typed;
    parse_result_t fixed;
  } byte_item_t;

  // one row of the directed table
  typedef struct {
    int unsigned nbytes;
    logic [3:0]  faults;
    fill_e       fill;
    logic        typed;
    status_t     want;
  } record_case_t;

  logic clk = 1'b0;
  logic rst;

  cbp_byte_if   byte_ch ();
  cbp_result_if result_ch ();

  config_blob_parser_crc32 i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .result (result_ch)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_item_t    stim_q[$];           // bytes waiting to be driven
  byte_item_t    on_wire_q[$];        // bytes driven, transfer not yet seen
  parse_result_t pending_results[$];  // results owed by the parser, oldest first
  record_case_t  directed_cases [16];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned random_bytes   = 0;
  logic        no_idle_stretch = 1'b0;

  // running image of the record being parsed
  int unsigned                rx_pos;
  logic [31:0]                rx_crc_acc;
  logic                       rx_magic_ok;
  logic [15:0]                rx_version;
  logic [15:0]                rx_length;
  logic [63:0]                rx_revision;
  logic [NUM_WORDS-1:0][31:0] rx_words;
  logic [15:0]                rx_batch;
  logic [31:0]                rx_crc_field;

  // reflected crc-32, one data bit at a time, lsb first
  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        feedback;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      feedback = c[0] ^ b[i];
      c = (c >> 1) ^ (feedback ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  // random field value, with a fair share of all-zero and all-ones
  function automatic logic [63:0] field_value(input fill_e fill);
    logic [3:0] roll;
    roll = 4'($urandom_range(15));
    case (fill)
      FILL_ZERO: return '0;
      FILL_ONES: return '1;
      default: begin
        if (roll == 4'd0) return '0;
        if (roll == 4'd1) return '1;
        return {$urandom, $urandom};
      end
    endcase
  endfunction

  function automatic bit take_gap();
    return !no_idle_stretch && ($urandom_range(99) < IDLE_PCT);
  endfunction

  task automatic clear_tracker();
    rx_pos       = 0;
    rx_crc_acc   = CRC_ONES;
    rx_magic_ok  = 1'b1;
    rx_version   = '0;
    rx_length    = '0;
    rx_revision  = '0;
    rx_words     = '0;
    rx_batch     = '0;
    rx_crc_field = '0;
  endtask

  // fold one accepted byte into the record image; on the last byte give the result
  task automatic absorb_record_byte(input logic [7:0] b, input logic last,
                                    output logic done, output parse_result_t res);
    int unsigned pos;
    int unsigned k;
    pos  = rx_pos;
    done = 1'b0;
    res  = '0;
    // bytes past the 50th change nothing
    if (pos < REC_BYTES) begin
      if (pos < POS_CRC) rx_crc_acc = crc32_update(rx_crc_acc, b);
      if (pos < POS_VERSION) begin
        if (b != MAGIC_WORD[8*pos +: 8]) rx_magic_ok = 1'b0;
      end else if (pos < POS_LENGTH) begin
        rx_version[8*(pos-POS_VERSION) +: 8] = b;
      end else if (pos < POS_REVISION) begin
        rx_length[8*(pos-POS_LENGTH) +: 8] = b;
      end else if (pos < POS_WORDS) begin
        rx_revision[8*(pos-POS_REVISION) +: 8] = b;
      end else if (pos < POS_BATCH) begin
        k = (pos - POS_WORDS) / 4;
        rx_words[k][8*((pos-POS_WORDS)%4) +: 8] = b;
      end else if (pos < POS_CRC) begin
        rx_batch[8*(pos-POS_BATCH) +: 8] = b;
      end else begin
        rx_crc_field[8*(pos-POS_CRC) +: 8] = b;
      end
      rx_pos = pos + 1;
    end
    if (last) begin
      done = 1'b1;
      // first failure wins; fields stay zero unless the record is good
      if (pos != LAST_POS) res.status = STAT_LENGTH;
      else if (!rx_magic_ok) res.status = STAT_MAGIC;
      else if (rx_version != WANT_VERSION) res.status = STAT_VERSION;
      else if (rx_length != WANT_PAYLOAD) res.status = STAT_PAYLOAD;
      else if (rx_crc_field != ~rx_crc_acc) res.status = STAT_CRC;
      else begin
        res.status   = STAT_OK;
        res.revision = rx_revision;
        res.words    = rx_words;
        res.batch    = rx_batch;
      end
      clear_tracker();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // build one record of nbytes bytes and put it on the stimulus queue
  task automatic queue_record(input int unsigned nbytes, input logic [3:0] faults,
                              input fill_e fill, input logic typed, input status_t want);
    logic [7:0]                 rec [MAX_REC_BYTES];
    logic [63:0]                revision;
    logic [NUM_WORDS-1:0][31:0] words;
    logic [15:0]                batch;
    logic [15:0]                version;
    logic [15:0]                length;
    logic [31:0]                crc;
    parse_result_t              fixed;
    byte_item_t                 item;
    revision = field_value(fill);
    for (int k = 0; k < NUM_WORDS; k++) words[k] = 32'(field_value(fill));
    batch   = 16'(field_value(fill));
    version = WANT_VERSION;
    length  = WANT_PAYLOAD;
    // xor with a nonzero value so a bad word can never hit the wanted one
    if ((faults & BAD_VERSION) != 0) version = WANT_VERSION ^ 16'($urandom_range(1, 65535));
    if ((faults & BAD_PAYLOAD) != 0) length = WANT_PAYLOAD ^ 16'($urandom_range(1, 65535));

    for (int i = 0; i < 4; i++) rec[i] = MAGIC_WORD[8*i +: 8];
    for (int i = 0; i < 2; i++) begin
      rec[POS_VERSION+i] = version[8*i +: 8];
      rec[POS_LENGTH+i]  = length[8*i +: 8];
      rec[POS_BATCH+i]   = batch[8*i +: 8];
    end
    for (int i = 0; i < 8; i++) rec[POS_REVISION+i] = revision[8*i +: 8];
    for (int i = 0; i < 4*NUM_WORDS; i++) rec[POS_WORDS+i] = words[i/4][8*(i%4) +: 8];
    crc = CRC_ONES;
    for (int i = 0; i < POS_CRC; i++) crc = crc32_update(crc, rec[i]);
    crc = ~crc;
    for (int i = 0; i < 4; i++) rec[POS_CRC+i] = crc[8*i +: 8];

    // corruptions land after the crc is sealed
    if ((faults & BAD_MAGIC) != 0) rec[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
    if ((faults & BAD_CRC) != 0)
      rec[$urandom_range(POS_REVISION, LAST_POS)] ^= 8'(1 << $urandom_range(7));
    // tail for overlong records
    for (int i = REC_BYTES; i < MAX_REC_BYTES; i++) rec[i] = 8'($urandom_range(255));

    fixed        = '0;
    fixed.status = want;
    if (want == STAT_OK && fill == FILL_ONES) begin
      fixed.revision = '1;
      fixed.words    = '1;
      fixed.batch    = '1;
    end
    for (int i = 0; i < nbytes; i++) begin
      item.data  = rec[i];
      item.last  = (i == nbytes - 1);
      item.typed = typed;
      item.fixed = fixed;
      stim_q.push_back(item);
    end
  endtask

  // drive every queued byte, one transfer each, with random gaps
  task automatic drive_stimulus();
    byte_item_t item;
    while (stim_q.size() != 0) begin
      item = stim_q.pop_front();
      while (take_gap()) begin
        byte_ch.valid <= 1'b0;
        @(posedge clk);
      end
      byte_ch.valid     <= 1'b1;
      byte_ch.data_byte <= item.data;
      byte_ch.last_byte <= item.last;
      on_wire_q.push_back(item);
      @(posedge clk);
      while (!byte_ch.ready) @(posedge clk);
      random_bytes++;
    end
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    result_ch.ready <= no_idle_stretch || ($urandom_range(99) >= IDLE_PCT);
  end

  // transfer monitor: check results against the oldest expectation, then track bytes
  always @(posedge clk) begin
    parse_result_t want;
    parse_result_t got;
    byte_item_t    item;
    logic          done;
    if (rst) begin
      clear_tracker();
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no record outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 64'(want.status), 64'(result_ch.status));
          check_field("revision", want.revision, result_ch.revision);
          check_field("minimum_on_ms", 64'(want.words[0]), 64'(result_ch.minimum_on_ms));
          check_field("motion_hold_ms", 64'(want.words[1]), 64'(result_ch.motion_hold_ms));
          check_field("sound_hold_ms", 64'(want.words[2]), 64'(result_ch.sound_hold_ms));
          check_field("sound_bridge_ms", 64'(want.words[3]),
                      64'(result_ch.sound_bridge_ms));
          check_field("cooldown_ms", 64'(want.words[4]), 64'(result_ch.cooldown_ms));
          check_field("sound_factor_bits", 64'(want.words[5]),
                      64'(result_ch.sound_factor_bits));
          check_field("telemetry_interval_ms", 64'(want.words[6]),
                      64'(result_ch.telemetry_interval_ms));
          check_field("batch_size", 64'(want.batch), 64'(result_ch.batch_size));
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        item = on_wire_q.pop_front();
        absorb_record_byte(byte_ch.data_byte, byte_ch.last_byte, done, got);
        // hand-typed rows override the tracker
        if (done) pending_results.push_back(item.typed ? item.fixed : got);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned random_records;
    int unsigned roll;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    rst               <= 1'b1;

    // nbytes, corruption, fill, typed, status
    directed_cases = '{
      '{1,  CLEAN, FILL_ZERO, 1'b1, STAT_LENGTH},              // one-byte record
      '{2,  CLEAN, FILL_ONES, 1'b1, STAT_LENGTH},
      '{49, CLEAN, FILL_ONES, 1'b1, STAT_LENGTH},              // one byte short
      '{51, CLEAN, FILL_ONES, 1'b1, STAT_LENGTH},              // one byte over
      '{60, CLEAN, FILL_RAND, 1'b1, STAT_LENGTH},              // well past saturation
      '{50, CLEAN, FILL_ZERO, 1'b1, STAT_OK},                  // fields all zero
      '{50, CLEAN, FILL_ONES, 1'b1, STAT_OK},                  // fields all ones
      '{50, BAD_MAGIC, FILL_RAND, 1'b1, STAT_MAGIC},
      '{50, BAD_VERSION, FILL_RAND, 1'b1, STAT_VERSION},
      '{50, BAD_PAYLOAD, FILL_RAND, 1'b1, STAT_PAYLOAD},
      '{50, BAD_CRC, FILL_RAND, 1'b1, STAT_CRC},
      // priority among several failures
      '{50, BAD_MAGIC | BAD_VERSION | BAD_PAYLOAD | BAD_CRC, FILL_ONES, 1'b1, STAT_MAGIC},
      '{50, BAD_VERSION | BAD_PAYLOAD | BAD_CRC, FILL_ZERO, 1'b1, STAT_VERSION},
      '{50, BAD_PAYLOAD | BAD_CRC, FILL_RAND, 1'b1, STAT_PAYLOAD},
      '{30, BAD_MAGIC, FILL_ZERO, 1'b1, STAT_LENGTH},          // length beats magic
      '{50, CLEAN, FILL_RAND, 1'b0, STAT_OK}                   // tracker decides
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_cases[i])
      queue_record(directed_cases[i].nbytes, directed_cases[i].faults, directed_cases[i].fill,
                   directed_cases[i].typed, directed_cases[i].want);
    drive_stimulus();

    // random part: mostly well-formed records, some broken, some noise
    random_bytes   = 0;
    random_records = 0;
    while (random_bytes < RANDOM_BYTES || random_records < RANDOM_RECORDS) begin
      // a run of records with both sides flat out
      no_idle_stretch = (random_records >= 2 && random_records < 8);
      roll = $urandom_range(99);
      if (roll < 55)      queue_record(REC_BYTES, CLEAN, FILL_RAND, 1'b0, STAT_OK);
      else if (roll < 62) queue_record(REC_BYTES, BAD_MAGIC, FILL_RAND, 1'b0, STAT_OK);
      else if (roll < 67) queue_record(REC_BYTES, BAD_VERSION, FILL_RAND, 1'b0, STAT_OK);
      else if (roll < 72) queue_record(REC_BYTES, BAD_PAYLOAD, FILL_RAND, 1'b0, STAT_OK);
      else if (roll < 80) queue_record(REC_BYTES, BAD_CRC, FILL_RAND, 1'b0, STAT_OK);
      else if (roll < 88)
        queue_record($urandom_range(1, LAST_POS), CLEAN, FILL_RAND, 1'b0, STAT_OK);
      else if (roll < 94)
        queue_record($urandom_range(REC_BYTES + 1, MAX_REC_BYTES), CLEAN, FILL_RAND,
                     1'b0, STAT_OK);
      else
        queue_record($urandom_range(1, MAX_REC_BYTES), 4'($urandom_range(15)), FILL_RAND,
                     1'b0, STAT_OK);
      drive_stimulus();
      random_records++;
    end
    no_idle_stretch = 1'b0;
    byte_ch.valid <= 1'b0;

    // let the last results drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
